// File: src/gbn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg: shared types and constants
// Field widths, request and packet codes, and defaults for the go-back-N
// sender window.
// ----------------------------------------------------------------------------
package gbn_pkg;

  // field widths
  localparam int unsigned ReqW    = 2;
  localparam int unsigned ChunkW  = 10;
  localparam int unsigned AckW    = 32;
  localparam int unsigned KindW   = 2;
  localparam int unsigned SeqW    = 31;
  localparam int unsigned OffsetW = 32;

  // defaults and limits
  localparam int unsigned WindowSizeDef = 8;
  localparam int unsigned MaxChunk      = 512;

  // acknowledge value that closes the transfer
  localparam logic [AckW-1:0] AckDone = {AckW{1'b1}};

  typedef enum logic [ReqW-1:0] {
    REQ_DATA    = 2'd0,
    REQ_END     = 2'd1,
    REQ_TIMEOUT = 2'd2,
    REQ_ACK     = 2'd3
  } req_e;

  typedef enum logic [KindW-1:0] {
    PKT_NONE = 2'd0,
    PKT_DATA = 2'd1,
    PKT_END  = 2'd2
  } pkt_kind_e;

endpackage : gbn_pkg
`default_nettype wire

// File: src/gbn_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data registered, old data returned
// when reading the entry being written.
// ----------------------------------------------------------------------------
module gbn_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 8,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]  wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output      logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule : gbn_ram
`default_nettype wire

// File: src/go_back_n_sender_window.sv
`default_nettype none
// A request beat passes the slot index stage, then the table read and update
// stage, then the output register.
// Throughput: one request per cycle while the result channel is not stalled,
// set by the read-modify-write of the slot offset table with write-to-read forwarding.
// Reset: counters and flags take their reset values at once; table valid bits
// clear together, so unwritten slots read as zero with no clearing pass.
// ----------------------------------------------------------------------------
// go_back_n_sender_window: go-back-N sender window bookkeeping
// Emits data and end marker headers, records per-slot offsets, and rewinds
// the window on timeout or on a short acknowledge.
// ----------------------------------------------------------------------------
module go_back_n_sender_window
  import gbn_pkg::*;
#(
  parameter int unsigned WINDOW_SIZE = WindowSizeDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // request channel
  input  wire logic                      in_valid_i,
  output      logic                      in_ready_o,
  input  wire logic [ReqW-1:0]           req_type_i,
  input  wire logic [ChunkW-1:0]         chunk_length_i,
  input  wire logic signed [AckW-1:0]    ack_value_i,
  // result channel
  output      logic                      out_valid_o,
  input  wire logic                      out_ready_i,
  output      logic [KindW-1:0]          pkt_kind_o,
  output      logic [SeqW-1:0]           pkt_seq_o,
  output      logic [OffsetW-1:0]        pkt_offset_o,
  output      logic [ChunkW-1:0]         pkt_length_o,
  output      logic                      seek_valid_o,
  output      logic [OffsetW-1:0]        seek_offset_o,
  output      logic                      wait_for_ack_o,
  output      logic                      finished_o,
  output      logic                      status_o
);

  localparam int unsigned SLOT_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam int unsigned REM_W  = 7;
  localparam int unsigned QW_W   = SeqW + REM_W;
  // floor((2^32 - 1) / W): quotient estimate is at most one short
  localparam longint unsigned RecipL = 64'h0000_0000_FFFF_FFFF / WINDOW_SIZE;
  localparam logic [31:0]     Recip  = RecipL[31:0];
  localparam logic [SLOT_W-1:0] LastSlot = SLOT_W'(WINDOW_SIZE - 1);
  localparam logic [REM_W-1:0]  WinRem   = REM_W'(WINDOW_SIZE);
  localparam logic [SeqW-1:0]   WinSeq   = SeqW'(WINDOW_SIZE);
  localparam logic [16:0]       MaxChunkL = 17'(MaxChunk);

  // --------------------------------------------------------------------------
  // pipeline handshake
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q;
  logic s1_fire, s2_fire;

  assign s2_fire    = s2_valid_q && (!out_valid_o || out_ready_i);
  assign s1_fire    = s1_valid_q && (!s2_valid_q || s2_fire);
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (!s2_valid_q || s2_fire) s2_valid_q <= s1_fire;
      if (!out_valid_o || out_ready_i) out_valid_o <= s2_fire;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: request capture and quotient estimate of ack / window
  // --------------------------------------------------------------------------
  logic [ReqW-1:0]   s1_req_q;
  logic [ChunkW-1:0] s1_chunk_q;
  logic [AckW-1:0]   s1_ack_q;
  logic [SeqW-1:0]   s1_quot_q;
  logic [62:0]       quot_prod;

  assign quot_prod = 63'(ack_value_i[SeqW-1:0]) * 63'(Recip);

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_req_q   <= req_type_i;
      s1_chunk_q <= chunk_length_i;
      s1_ack_q   <= $unsigned(ack_value_i);
      s1_quot_q  <= quot_prod[62:32];
    end
  end

  // remainder with a single correction step
  logic [QW_W-1:0]   quot_w;
  logic [QW_W-1:0]   rem_full;
  logic [REM_W-1:0]  rem_raw;
  logic [REM_W-1:0]  rem_fix;
  logic [SLOT_W-1:0] rd_slot;

  always_comb begin
    quot_w   = QW_W'(s1_quot_q) * QW_W'(WINDOW_SIZE);
    rem_full = QW_W'(s1_ack_q[SeqW-1:0]) - quot_w;
    rem_raw  = rem_full[REM_W-1:0];
    rem_fix  = (rem_raw >= WinRem) ? (rem_raw - WinRem) : rem_raw;
    rd_slot  = rem_fix[SLOT_W-1:0];
  end

  // --------------------------------------------------------------------------
  // slot offset table, valid bits and forwarding
  // --------------------------------------------------------------------------
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  logic [OffsetW-1:0] ram_wdata;
  logic [OffsetW-1:0] ram_rdata;
  logic [WINDOW_SIZE-1:0] slot_valid_q;

  gbn_ram #(
    .WIDTH (OffsetW),
    .DEPTH (WINDOW_SIZE)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (s1_fire),
    .raddr_i (rd_slot),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
    end else if (ram_we) begin
      slot_valid_q[ram_waddr] <= 1'b1;
    end
  end

  // stage 2 payload, with forwarding of a write that meets the read
  logic [ReqW-1:0]    s2_req_q;
  logic [ChunkW-1:0]  s2_chunk_q;
  logic [AckW-1:0]    s2_ack_q;
  logic [SLOT_W-1:0]  s2_slot_q;
  logic               s2_fwd_q;
  logic [OffsetW-1:0] s2_fwd_data_q;
  logic               s2_entry_valid_q;

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      s2_req_q         <= s1_req_q;
      s2_chunk_q       <= s1_chunk_q;
      s2_ack_q         <= s1_ack_q;
      s2_slot_q        <= rd_slot;
      s2_fwd_q         <= ram_we && (ram_waddr == rd_slot);
      s2_fwd_data_q    <= ram_wdata;
      s2_entry_valid_q <= slot_valid_q[rd_slot];
    end
  end

  logic [OffsetW-1:0] table_offset;

  always_comb begin
    if (s2_fwd_q) begin
      table_offset = s2_fwd_data_q;
    end else if (s2_entry_valid_q) begin
      table_offset = ram_rdata;
    end else begin
      table_offset = '0;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: window state update
  // --------------------------------------------------------------------------
  logic [SeqW-1:0]    next_seq_q, next_seq_d;
  logic [SLOT_W-1:0]  window_slot_q, window_slot_d;
  logic [SeqW-1:0]    sent_total_q, sent_total_d;
  logic [OffsetW-1:0] cur_offset_q, cur_offset_d;
  logic [OffsetW-1:0] win_offset_q, win_offset_d;
  logic               awaiting_q, awaiting_d;
  logic               done_q, done_d;

  pkt_kind_e          kind;
  logic [SeqW-1:0]    seq;
  logic [OffsetW-1:0] off;
  logic [ChunkW-1:0]  len;
  logic               seek;
  logic [OffsetW-1:0] seek_off;
  logic               reject;
  logic               wr_req;
  req_e               req;

  always_comb begin
    next_seq_d    = next_seq_q;
    window_slot_d = window_slot_q;
    sent_total_d  = sent_total_q;
    cur_offset_d  = cur_offset_q;
    win_offset_d  = win_offset_q;
    awaiting_d    = awaiting_q;
    done_d        = done_q;
    kind          = PKT_NONE;
    seq           = '0;
    off           = '0;
    len           = '0;
    seek          = 1'b0;
    seek_off      = '0;
    reject        = 1'b0;
    wr_req        = 1'b0;
    req           = req_e'(s2_req_q);

    if (done_q) begin
      reject = 1'b1;
    end else begin
      unique case (req)
        REQ_DATA, REQ_END: begin
          if (awaiting_q || (req == REQ_DATA && 17'(s2_chunk_q) > MaxChunkL)) begin
            reject = 1'b1;
          end else if (req == REQ_END) begin
            kind = PKT_END;
            seq  = next_seq_q;
            off  = cur_offset_q;
          end else begin
            // data beat: record offset and advance the window
            kind         = PKT_DATA;
            seq          = next_seq_q;
            off          = cur_offset_q;
            len          = s2_chunk_q;
            wr_req       = 1'b1;
            cur_offset_d = cur_offset_q + OffsetW'(s2_chunk_q);
            next_seq_d   = next_seq_q + SeqW'(1);
            sent_total_d = sent_total_q + SeqW'(1);
            if (window_slot_q == LastSlot) begin
              window_slot_d = '0;
              awaiting_d    = 1'b1;
            end else begin
              window_slot_d = window_slot_q + SLOT_W'(1);
            end
          end
        end
        REQ_TIMEOUT, REQ_ACK: begin
          if (!awaiting_q) begin
            reject = 1'b1;
          end else if (req == REQ_TIMEOUT) begin
            // rewind the whole window
            sent_total_d = (sent_total_q >= WinSeq) ? (sent_total_q - WinSeq) : '0;
            cur_offset_d = win_offset_q;
            next_seq_d   = sent_total_d + SeqW'(1);
            awaiting_d   = 1'b0;
            seek         = 1'b1;
            seek_off     = win_offset_q;
          end else if (s2_ack_q == AckDone) begin
            done_d     = 1'b1;
            awaiting_d = 1'b0;
          end else if (s2_ack_q[AckW-1]) begin
            reject = 1'b1;
          end else if (s2_ack_q[SeqW-1:0] == sent_total_q) begin
            // full window acknowledged
            win_offset_d = cur_offset_q;
            awaiting_d   = 1'b0;
          end else begin
            // short acknowledge: go back to its slot
            sent_total_d  = s2_ack_q[SeqW-1:0];
            window_slot_d = s2_slot_q;
            win_offset_d  = table_offset;
            cur_offset_d  = table_offset;
            next_seq_d    = s2_ack_q[SeqW-1:0] + SeqW'(1);
            awaiting_d    = 1'b0;
            seek          = 1'b1;
            seek_off      = table_offset;
          end
        end
        default: begin
          reject = 1'b1;
        end
      endcase
    end
  end

  assign ram_we    = s2_fire && wr_req;
  assign ram_waddr = window_slot_q;
  assign ram_wdata = cur_offset_q;

  // window state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_seq_q    <= SeqW'(1);
      window_slot_q <= '0;
      sent_total_q  <= '0;
      cur_offset_q  <= '0;
      win_offset_q  <= '0;
      awaiting_q    <= 1'b0;
      done_q        <= 1'b0;
    end else if (s2_fire) begin
      next_seq_q    <= next_seq_d;
      window_slot_q <= window_slot_d;
      sent_total_q  <= sent_total_d;
      cur_offset_q  <= cur_offset_d;
      win_offset_q  <= win_offset_d;
      awaiting_q    <= awaiting_d;
      done_q        <= done_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (s2_fire) begin
      pkt_kind_o     <= kind;
      pkt_seq_o      <= seq;
      pkt_offset_o   <= off;
      pkt_length_o   <= len;
      seek_valid_o   <= seek;
      seek_offset_o  <= seek_off;
      wait_for_ack_o <= awaiting_d;
      finished_o     <= done_d;
      status_o       <= reject;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_done_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> done_q)
    else $error("transfer done flag cleared");

  a_slot_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(window_slot_q) < WINDOW_SIZE)
    else $error("window slot beyond window");

  a_read_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_valid_q && !s2_fire) |-> !s1_fire)
    else $error("table read while stage 2 is stalled");

  a_reject_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (pkt_kind_o == PKT_NONE && !seek_valid_o))
    else $error("rejected beat carries a packet or seek");

  a_seek_clears_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && seek_valid_o) |-> (!wait_for_ack_o && !finished_o))
    else $error("seek issued while still awaiting a reply");

endmodule : go_back_n_sender_window
`default_nettype wire

// File: sim/gbn_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_checker: result checker for the go-back-N sender window
// Watches the request and result channels, predicts every result beat from
// its request beat with a copy of the window state, and compares each result
// field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module gbn_checker
  import gbn_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // request channel
  input  wire logic               in_valid_i,
  input  wire logic               in_ready_i,
  input  wire logic [ReqW-1:0]    req_type_i,
  input  wire logic [ChunkW-1:0]  chunk_length_i,
  input  wire logic [AckW-1:0]    ack_value_i,
  // result channel
  input  wire logic               out_valid_i,
  input  wire logic               out_ready_i,
  input  wire logic [KindW-1:0]   pkt_kind_i,
  input  wire logic [SeqW-1:0]    pkt_seq_i,
  input  wire logic [OffsetW-1:0] pkt_offset_i,
  input  wire logic [ChunkW-1:0]  pkt_length_i,
  input  wire logic               seek_valid_i,
  input  wire logic [OffsetW-1:0] seek_offset_i,
  input  wire logic               wait_for_ack_i,
  input  wire logic               finished_i,
  input  wire logic               status_i,
  // verdict and window state for the stimulus side
  output int unsigned             fail_count_o,
  output int unsigned             pending_o,
  output logic                    awaiting_o,
  output logic                    done_o,
  output logic [SeqW-1:0]         sent_total_o
);

  localparam int unsigned Win   = WindowSizeDef;
  localparam int unsigned SlotW = $clog2(Win);

  typedef struct packed {
    pkt_kind_e          kind;
    logic [SeqW-1:0]    seq;
    logic [OffsetW-1:0] offset;
    logic [ChunkW-1:0]  length;
    logic               seek;
    logic [OffsetW-1:0] seek_off;
    logic               waiting;
    logic               done;
    logic               rejected;
  } pkt_result_t;

  // predicted window state
  logic [SeqW-1:0]    seq_next;
  logic [SeqW-1:0]    sent_cnt;
  logic [SlotW-1:0]   slot_idx;
  logic [OffsetW-1:0] cur_off;
  logic [OffsetW-1:0] win_off;
  logic [OffsetW-1:0] slot_off [Win];
  logic               awaiting;
  logic               done;

  pkt_result_t expected_pkts [$];
  int unsigned fails = 0;

  // one request through the window bookkeeping
  task automatic window_step(input req_e req, input logic [ChunkW-1:0] chunk,
                             input logic [AckW-1:0] ack, output pkt_result_t res);
    res = '0;
    if (done) begin
      res.rejected = 1'b1;
    end else if (req == REQ_DATA || req == REQ_END) begin
      if (awaiting || (req == REQ_DATA && 32'(chunk) > MaxChunk)) begin
        res.rejected = 1'b1;
      end else if (req == REQ_END) begin
        res.kind   = PKT_END;
        res.seq    = seq_next;
        res.offset = cur_off;
      end else begin
        res.kind   = PKT_DATA;
        res.seq    = seq_next;
        res.offset = cur_off;
        res.length = chunk;
        slot_off[slot_idx] = cur_off;
        cur_off  = cur_off + OffsetW'(chunk);
        seq_next = seq_next + SeqW'(1);
        sent_cnt = sent_cnt + SeqW'(1);
        if (slot_idx == SlotW'(Win - 1)) begin
          slot_idx = '0;
          awaiting = 1'b1;
        end else begin
          slot_idx = slot_idx + SlotW'(1);
        end
      end
    end else if (!awaiting) begin
      res.rejected = 1'b1;
    end else if (req == REQ_TIMEOUT) begin
      // rewind the whole window, sent count saturating at zero
      sent_cnt     = (sent_cnt >= SeqW'(Win)) ? sent_cnt - SeqW'(Win) : '0;
      cur_off      = win_off;
      seq_next     = sent_cnt + SeqW'(1);
      awaiting     = 1'b0;
      res.seek     = 1'b1;
      res.seek_off = win_off;
    end else if (ack == AckDone) begin
      done     = 1'b1;
      awaiting = 1'b0;
    end else if (ack[AckW-1]) begin
      res.rejected = 1'b1;
    end else if (ack[SeqW-1:0] == sent_cnt) begin
      // full ack commits the window
      win_off  = cur_off;
      awaiting = 1'b0;
    end else begin
      // short or stale ack reloads the slot as stored
      sent_cnt     = ack[SeqW-1:0];
      slot_idx     = SlotW'(ack % Win);
      win_off      = slot_off[slot_idx];
      cur_off      = win_off;
      seq_next     = ack[SeqW-1:0] + SeqW'(1);
      awaiting     = 1'b0;
      res.seek     = 1'b1;
      res.seek_off = win_off;
    end
    res.waiting = awaiting;
    res.done    = done;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // predict on request beats, compare on result beats
  always @(posedge clk_i or negedge rst_ni) begin : track
    pkt_result_t want;
    if (!rst_ni) begin
      seq_next = SeqW'(1);
      sent_cnt = '0;
      slot_idx = '0;
      cur_off  = '0;
      win_off  = '0;
      awaiting = 1'b0;
      done     = 1'b0;
      foreach (slot_off[i]) slot_off[i] = '0;
      expected_pkts.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_pkts.size() == 0) begin
          $error("result beat with no request waiting");
          fails++;
        end else begin
          want = expected_pkts.pop_front();
          check_field("pkt_kind", 32'(want.kind), 32'(pkt_kind_i));
          check_field("pkt_seq", 32'(want.seq), 32'(pkt_seq_i));
          check_field("pkt_offset", want.offset, pkt_offset_i);
          check_field("pkt_length", 32'(want.length), 32'(pkt_length_i));
          check_field("seek_valid", 32'(want.seek), 32'(seek_valid_i));
          check_field("seek_offset", want.seek_off, seek_offset_i);
          check_field("wait_for_ack", 32'(want.waiting), 32'(wait_for_ack_i));
          check_field("finished", 32'(want.done), 32'(finished_i));
          check_field("status", 32'(want.rejected), 32'(status_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        window_step(req_e'(req_type_i), chunk_length_i, ack_value_i, want);
        expected_pkts.push_back(want);
      end
    end
    fail_count_o = fails;
    pending_o    = expected_pkts.size();
    awaiting_o   = awaiting;
    done_o       = done;
    sent_total_o = sent_cnt;
  end

endmodule : gbn_checker
`default_nettype wire

// File: sim/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb: testbench for the go-back-N sender window
// Drives a directed opening and then mostly well-formed window traffic with
// random content, random idling on both channels, two long receiver hold-offs
// and sender pauses until drained; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import gbn_pkg::*;

  localparam int unsigned Win        = WindowSizeDef;
  localparam int unsigned RandomReqs = 1720;

  logic                      clk_i          = 1'b0;
  logic                      rst_ni         = 1'b0;
  logic                      in_valid_i     = 1'b0;
  logic                      in_ready_o;
  logic [ReqW-1:0]           req_type_i     = '0;
  logic [ChunkW-1:0]         chunk_length_i = '0;
  logic signed [AckW-1:0]    ack_value_i    = '0;
  logic                      out_valid_o;
  logic                      out_ready_i    = 1'b0;
  logic [KindW-1:0]          pkt_kind_o;
  logic [SeqW-1:0]           pkt_seq_o;
  logic [OffsetW-1:0]        pkt_offset_o;
  logic [ChunkW-1:0]         pkt_length_o;
  logic                      seek_valid_o;
  logic [OffsetW-1:0]        seek_offset_o;
  logic                      wait_for_ack_o;
  logic                      finished_o;
  logic                      status_o;

  int unsigned               fail_count;
  int unsigned               pending;
  logic                      model_waiting;
  logic                      model_done;
  logic [SeqW-1:0]           model_sent;

  // no random idling on either side while set
  bit                        calm = 1'b0;

  go_back_n_sender_window DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .chunk_length_i (chunk_length_i),
    .ack_value_i    (ack_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pkt_kind_o     (pkt_kind_o),
    .pkt_seq_o      (pkt_seq_o),
    .pkt_offset_o   (pkt_offset_o),
    .pkt_length_o   (pkt_length_o),
    .seek_valid_o   (seek_valid_o),
    .seek_offset_o  (seek_offset_o),
    .wait_for_ack_o (wait_for_ack_o),
    .finished_o     (finished_o),
    .status_o       (status_o)
  );

  gbn_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .req_type_i     (req_type_i),
    .chunk_length_i (chunk_length_i),
    .ack_value_i    (ack_value_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .pkt_kind_i     (pkt_kind_o),
    .pkt_seq_i      (pkt_seq_o),
    .pkt_offset_i   (pkt_offset_o),
    .pkt_length_i   (pkt_length_o),
    .seek_valid_i   (seek_valid_o),
    .seek_offset_i  (seek_offset_o),
    .wait_for_ack_i (wait_for_ack_o),
    .finished_i     (finished_o),
    .status_i       (status_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .awaiting_o     (model_waiting),
    .done_o         (model_done),
    .sent_total_o   (model_sent)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  initial begin : watchdog
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // sender gap before a request beat
  task automatic hold_gap();
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // offer one request beat and wait until it is taken
  task automatic offer_req(input req_e r, input logic [ChunkW-1:0] c,
                           input logic [AckW-1:0] a);
    in_valid_i     <= 1'b1;
    req_type_i     <= r;
    chunk_length_i <= c;
    ack_value_i    <= a;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic send_req(input req_e r, input logic [ChunkW-1:0] c,
                          input logic [AckW-1:0] a);
    hold_gap();
    offer_req(r, c, a);
  endtask

  // sender waits with valid low until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  // choose a request that mostly follows the window protocol
  task automatic pick_req(output req_e r, output logic [ChunkW-1:0] c,
                          output logic [AckW-1:0] a);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    c = ChunkW'($urandom_range(0, MaxChunk));
    if ($urandom_range(0, 19) == 0) c = ChunkW'($urandom);
    a = $urandom;
    if (!model_waiting) begin
      if (roll < 84)      r = REQ_DATA;
      else if (roll < 90) r = REQ_END;
      else if (roll < 95) r = REQ_TIMEOUT;
      else                r = REQ_ACK;
    end else if (roll < 8) begin
      r = (roll < 4) ? REQ_DATA : REQ_END;
    end else if (roll < 30) begin
      r = REQ_TIMEOUT;
    end else begin
      r = REQ_ACK;
      if (roll < 62)      a = {1'b0, model_sent};
      else if (roll < 82) a = {1'b0, model_sent - SeqW'($urandom_range(1, 2 * Win))};
      // near the top of the sequence space so the counters wrap
      else if (roll < 87) a = {1'b0, {SeqW{1'b1}}} - $urandom_range(0, 2 * Win);
      else if (roll < 92) a = {1'b0, SeqW'($urandom)};
      if (a == AckDone) a = AckDone - 1;
    end
  endtask

  // receiver: random stall per beat, two long hold-offs
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == 250 || taken == 1000) stall = 400;
      else stall = calm ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  // reset, stimulus and verdict
  initial begin : stimulus
    req_e             r;
    logic [ChunkW-1:0] c;
    logic [AckW-1:0]   a;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: out-of-state requests, extremes, full window, rewinds
    send_req(REQ_TIMEOUT, '0, '0);
    send_req(REQ_ACK, '0, '0);
    send_req(REQ_END, '1, '0);
    send_req(REQ_DATA, ChunkW'(MaxChunk + 1), '0);
    send_req(REQ_DATA, '1, '1);
    send_req(REQ_DATA, ChunkW'(MaxChunk), '0);
    send_req(REQ_DATA, '0, '0);
    repeat (Win - 2) send_req(REQ_DATA, ChunkW'($urandom_range(0, MaxChunk)), $urandom);
    send_req(REQ_DATA, 10'd1, '0);
    send_req(REQ_END, '0, '0);
    send_req(REQ_ACK, '0, AckDone - 1);
    send_req(REQ_ACK, '0, 32'h8000_0000);
    send_req(REQ_ACK, '0, 32'd3);
    repeat (Win - 3) send_req(REQ_DATA, ChunkW'($urandom_range(0, MaxChunk)), '0);
    send_req(REQ_TIMEOUT, '0, '1);

    // random traffic in stretches, some without idling
    for (int unsigned n = 0; n < RandomReqs; n++) begin
      if (n % 120 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == 600 || n == 1300) drain_results();
      hold_gap();
      pick_req(r, c, a);
      offer_req(r, c, a);
    end

    // close the transfer, then everything is refused
    calm = 1'b0;
    while (!model_waiting) begin
      send_req(REQ_DATA, ChunkW'($urandom_range(0, MaxChunk)), $urandom);
    end
    send_req(REQ_ACK, ChunkW'($urandom), AckDone);
    send_req(REQ_DATA, 10'd5, '0);
    send_req(REQ_END, '0, '0);
    send_req(REQ_TIMEOUT, '0, '0);
    send_req(REQ_ACK, '0, AckDone);

    drain_results();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule : tb
`default_nettype wire
